FILE: hdl/iai_pkg.sv
// Shared types and constants for the ignition advance interpolator.
// Holds the breakpoint and span tables, register codes and queue records.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package iai_pkg;

   // Field widths.
   localparam int unsigned PERIOD_WIDTH      = 16;
   localparam int unsigned ADV_WIDTH         = 16;
   localparam int unsigned WINDOW_WIDTH      = 12;  // periods inside the window are below 3000
   localparam int unsigned OFFSET_WIDTH      = 10;  // offset into a span, widest span is 945
   localparam int unsigned PRODUCT_WIDTH     = 26;  // |advance step| times offset
   localparam int unsigned RECIP_WIDTH       = 32;
   localparam int unsigned RECIP_PROD_WIDTH  = PRODUCT_WIDTH + RECIP_WIDTH;
   localparam int unsigned NUM_POINTS        = 9;
   localparam int unsigned NUM_SPANS         = NUM_POINTS - 1;
   localparam int unsigned POINT_IDX_WIDTH   = $clog2(NUM_POINTS + 1);
   localparam int unsigned SPAN_IDX_WIDTH    = $clog2(NUM_SPANS);
   localparam int unsigned CSR_INDEX_WIDTH   = 3;
   localparam int unsigned CSR_DATA_WIDTH    = 32;
   localparam int unsigned QUEUE_DEPTH       = 2;
   localparam int unsigned QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Request type codes.
   localparam logic REQ_PULSE    = 1'b0;
   localparam logic REQ_OVERFLOW = 1'b1;

   // Acceptance window for crank periods, both ends excluded.
   localparam logic [PERIOD_WIDTH-1:0] WIN_LOW  = 16'd150;
   localparam logic [PERIOD_WIDTH-1:0] WIN_HIGH = 16'd3000;

   // Breakpoints in falling order; entry k of the advance table belongs to BREAKPOINT[k].
   localparam logic [WINDOW_WIDTH-1:0] BREAKPOINT [NUM_POINTS] = '{
      12'd2750, 12'd1890, 12'd945, 12'd630, 12'd472, 12'd378, 12'd315, 12'd270, 12'd236
   };

   // Span k runs from BREAKPOINT[k+1] up to BREAKPOINT[k].
   localparam logic [OFFSET_WIDTH-1:0] SPAN [NUM_SPANS] = '{
      10'd860, 10'd945, 10'd315, 10'd158, 10'd94, 10'd63, 10'd45, 10'd34
   };

   // floor(2^32 / span); the estimate it gives is low by at most one.
   localparam logic [RECIP_WIDTH-1:0] SPAN_RECIP [NUM_SPANS] = '{
      32'((64'd1 << 32) / 64'd860),
      32'((64'd1 << 32) / 64'd945),
      32'((64'd1 << 32) / 64'd315),
      32'((64'd1 << 32) / 64'd158),
      32'((64'd1 << 32) / 64'd94),
      32'((64'd1 << 32) / 64'd63),
      32'((64'd1 << 32) / 64'd45),
      32'((64'd1 << 32) / 64'd34)
   };

   // Advance table contents after reset.
   localparam logic [ADV_WIDTH-1:0] ADV_RESET [NUM_POINTS] = '{
      16'd87, 16'd120, 16'd87, 16'd70, 16'd60, 16'd52, 16'd42, 16'd37, 16'd32
   };

   localparam logic [ADV_WIDTH-1:0] COMPARE_RESET = 16'h0041;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADV_PAIR_0_1 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADV_PAIR_2_3 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADV_PAIR_4_5 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADV_PAIR_6_7 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADV_LAST     = 3'd4;

   typedef enum logic [1:0] {
      KIND_OVERFLOW,
      KIND_PULSE,
      KIND_REJECT
   } item_kind_type;

   // A classified word as it waits in the queue.
   typedef struct packed {
      item_kind_type                kind;
      logic                         interp;
      logic [POINT_IDX_WIDTH-1:0]   lo_idx;
      logic [OFFSET_WIDTH-1:0]      offset;
      logic [WINDOW_WIDTH-1:0]      period;
   } queue_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: hdl/ignition_advance_interpolator_unit.sv
// Ignition advance interpolator, top level.
// Ties the classifying front end, the word queue and the interpolating back end.
// Depends on iai_pkg, iai_front, iai_queue and iai_back.
//
// Usage:
//   Request words arrive on req_valid/req_stall with req_type (0 crank pulse,
//   1 timer overflow tick) and req_period. A word is taken at a rising edge
//   with req_valid high and req_stall low. Every word yields exactly one
//   result word on rsp_valid/rsp_stall, in order, carrying the spark compare,
//   the latest advance, the stop flag, the pulse-accepted flag and the
//   revolution count as they stand after that word.
//   From acceptance to rsp_valid a word passes the front register, the queue,
//   then the multiply, reciprocal estimate and correction stages, and the
//   state/result register. Throughput is one word per cycle while rsp_stall
//   is low; the multiply stages are fully pipelined.
//   When the receiver raises rsp_stall the whole back end holds; the queue and
//   front register keep absorbing words until they fill, and only then is
//   req_stall raised. The advance table is written through csr_valid/csr_index/
//   csr_wdata (csr_ready is always high) while no word is in flight.
//   Reset is synchronous and restores the default advance table, a compare of
//   0x41, a cleared stop and overflow state and a zero revolution count.
`timescale 1ns / 1ps
`default_nettype none

module ignition_advance_interpolator_unit #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_type,
   input  wire logic [iai_pkg::PERIOD_WIDTH-1:0]     req_period,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [iai_pkg::ADV_WIDTH-1:0]             rsp_spark_compare,
   output logic [iai_pkg::ADV_WIDTH-1:0]             rsp_advance_ticks,
   output logic                                      rsp_stopped,
   output logic                                      rsp_pulse_accepted,
   output logic [iai_pkg::ADV_WIDTH-1:0]             rsp_revolutions,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [iai_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [iai_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import iai_pkg::*;

   // Classified words travel from the front end into the queue.
   queue_item_type   push_item;
   logic             push_valid;
   // The back end pops the queue head whenever its pipeline moves.
   queue_item_type   pop_item;
   logic             pop;
   queue_status_type q_status;

   // The front end masks the period to the timer width and finds the span.
   iai_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_period (req_period),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // Two-entry queue that lets the front keep taking words while the back holds.
   iai_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .pop_item   (pop_item),
      .q_status   (q_status)
   );

   // The back end owns the advance table and all engine state.
   iai_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_item           (pop_item),
      .q_status           (q_status),
      .pop                (pop),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_spark_compare  (rsp_spark_compare),
      .rsp_advance_ticks  (rsp_advance_ticks),
      .rsp_stopped        (rsp_stopped),
      .rsp_pulse_accepted (rsp_pulse_accepted),
      .rsp_revolutions    (rsp_revolutions)
   );

endmodule

`default_nettype wire

FILE: hdl/iai_front.sv
// Front end of the ignition advance interpolator: takes request words and
// classifies them into overflow, accepted pulse or rejected pulse with span.
// Depends on iai_pkg; feeds iai_queue.
`timescale 1ns / 1ps
`default_nettype none

module iai_front #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic [iai_pkg::PERIOD_WIDTH-1:0]    req_period,
   input  iai_pkg::queue_status_type                q_status,
   output logic                                     push_valid,
   output iai_pkg::queue_item_type                  push_item
);
   import iai_pkg::*;

   localparam int unsigned KEEP_BITS =
      (COUNT_WIDTH < PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_MASK =
      {PERIOD_WIDTH{1'b1}} >> (PERIOD_WIDTH - KEEP_BITS);

   logic [PERIOD_WIDTH-1:0]    period_masked;
   logic [POINT_IDX_WIDTH-1:0] above_count;
   queue_item_type             sorted_item;
   queue_item_type             item_ff, item_in;
   logic                       valid_ff, valid_in;
   logic                       take;

   // Breakpoints fall, so the number at or above the period picks the span.
   always_comb begin
      period_masked = req_period & PERIOD_MASK;
      above_count   = '0;
      for (int k = 0; k < NUM_POINTS; k++) begin
         if (PERIOD_WIDTH'(BREAKPOINT[k]) >= period_masked) begin
            above_count = above_count + 1'b1;
         end
      end

      sorted_item        = '0;
      sorted_item.kind   = KIND_REJECT;
      sorted_item.period = period_masked[WINDOW_WIDTH-1:0];
      if (req_type == REQ_OVERFLOW) begin
         sorted_item.kind = KIND_OVERFLOW;
      end else if (period_masked > WIN_LOW && period_masked < WIN_HIGH) begin
         sorted_item.kind = KIND_PULSE;
         if (above_count == '0) begin
            sorted_item.lo_idx = '0;
         end else if (above_count == POINT_IDX_WIDTH'(NUM_POINTS)) begin
            sorted_item.lo_idx = POINT_IDX_WIDTH'(NUM_POINTS - 1);
         end else begin
            sorted_item.lo_idx = above_count;
            sorted_item.interp = 1'b1;
            sorted_item.offset = OFFSET_WIDTH'(period_masked
                                 - PERIOD_WIDTH'(BREAKPOINT[above_count]));
         end
      end
   end

   assign req_stall  = valid_ff && q_status.full;
   assign take       = req_valid && !req_stall;
   assign push_valid = valid_ff && !q_status.full;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = sorted_item;
      end else if (push_valid) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

FILE: hdl/iai_queue.sv
// Short queue of classified words between front and back end.
// Depends on iai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iai_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  iai_pkg::queue_item_type   push_item,
   input  wire logic                 pop,
   output iai_pkg::queue_item_type   pop_item,
   output iai_pkg::queue_status_type q_status
);
   import iai_pkg::*;

   queue_item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/iai_back.sv
// Back end of the ignition advance interpolator: advance table, interpolation
// pipeline (multiply, reciprocal divide, correction) and the engine state.
// Depends on iai_pkg; reads words from iai_queue.
`timescale 1ns / 1ps
`default_nettype none

module iai_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  iai_pkg::queue_item_type                   pop_item,
   input  iai_pkg::queue_status_type                 q_status,
   output logic                                      pop,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [iai_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [iai_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [iai_pkg::ADV_WIDTH-1:0]             rsp_spark_compare,
   output logic [iai_pkg::ADV_WIDTH-1:0]             rsp_advance_ticks,
   output logic                                      rsp_stopped,
   output logic                                      rsp_pulse_accepted,
   output logic [iai_pkg::ADV_WIDTH-1:0]             rsp_revolutions
);
   import iai_pkg::*;

   typedef struct packed {
      item_kind_type               kind;
      logic                        neg;
      logic [PRODUCT_WIDTH-1:0]    prod;
      logic [ADV_WIDTH-1:0]        a_lo;
      logic [SPAN_IDX_WIDTH-1:0]   span_idx;
      logic [WINDOW_WIDTH-1:0]     period;
   } mul_stage_type;

   typedef struct packed {
      item_kind_type               kind;
      logic                        neg;
      logic [PRODUCT_WIDTH-1:0]    prod;
      logic [ADV_WIDTH-1:0]        a_lo;
      logic [SPAN_IDX_WIDTH-1:0]   span_idx;
      logic [WINDOW_WIDTH-1:0]     period;
      logic [ADV_WIDTH-1:0]        q_est;
   } est_stage_type;

   typedef struct packed {
      item_kind_type               kind;
      logic                        neg;
      logic [ADV_WIDTH-1:0]        a_lo;
      logic [WINDOW_WIDTH-1:0]     period;
      logic [ADV_WIDTH-1:0]        quot;
   } quot_stage_type;

   // Advance table.
   logic [ADV_WIDTH-1:0] tab_ff [NUM_POINTS];
   logic [ADV_WIDTH-1:0] tab_in [NUM_POINTS];

   // Pipeline.
   logic           advance;
   mul_stage_type  s1_ff, s1_in;
   est_stage_type  s2_ff, s2_in;
   quot_stage_type s3_ff, s3_in;
   logic           s1_valid_ff, s1_valid_in;
   logic           s2_valid_ff, s2_valid_in;
   logic           s3_valid_ff, s3_valid_in;

   // Engine state, which is also the result word.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 overflow_ff, overflow_in;
   logic                 stop_ff, stop_in;
   logic                 accepted_ff, accepted_in;
   logic [ADV_WIDTH-1:0] compare_ff, compare_in;
   logic [ADV_WIDTH-1:0] adv_reg_ff, adv_reg_in;
   logic [ADV_WIDTH-1:0] rev_ff, rev_in;

   logic [ADV_WIDTH-1:0]        a_lo, a_hi;
   logic [ADV_WIDTH:0]          step;
   logic [ADV_WIDTH-1:0]        step_mag;
   logic [RECIP_PROD_WIDTH-1:0] recip_product;
   logic [PRODUCT_WIDTH-1:0]    back_product;
   logic [PRODUCT_WIDTH-1:0]    remainder;
   logic [ADV_WIDTH:0]          adv_sum;
   logic [ADV_WIDTH-1:0]        adv_new;
   logic [ADV_WIDTH-1:0]        period_ext;
   logic [ADV_WIDTH-1:0]        compare_new;

   // The whole back end moves together unless a finished word is held.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign pop       = advance && !q_status.empty;
   assign csr_ready = 1'b1;

   // Configuration writes land in table pairs; the last entry is written alone.
   always_comb begin
      tab_in = tab_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ADV_PAIR_0_1: begin
               tab_in[0] = csr_wdata[15:0];
               tab_in[1] = csr_wdata[31:16];
            end
            CSR_ADV_PAIR_2_3: begin
               tab_in[2] = csr_wdata[15:0];
               tab_in[3] = csr_wdata[31:16];
            end
            CSR_ADV_PAIR_4_5: begin
               tab_in[4] = csr_wdata[15:0];
               tab_in[5] = csr_wdata[31:16];
            end
            CSR_ADV_PAIR_6_7: begin
               tab_in[6] = csr_wdata[15:0];
               tab_in[7] = csr_wdata[31:16];
            end
            CSR_ADV_LAST: begin
               tab_in[8] = csr_wdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage 1: pick the two table entries of the span and form |step| * offset.
   always_comb begin
      a_lo = tab_ff[0];
      a_hi = tab_ff[0];
      for (int k = 0; k < NUM_POINTS; k++) begin
         if (pop_item.lo_idx == POINT_IDX_WIDTH'(k)) begin
            a_lo = tab_ff[k];
            a_hi = tab_ff[(k == 0) ? 0 : k - 1];
         end
      end
      step     = {1'b0, a_hi} - {1'b0, a_lo};
      step_mag = step[ADV_WIDTH] ? ADV_WIDTH'(-step) : step[ADV_WIDTH-1:0];

      s1_in.kind     = pop_item.kind;
      s1_in.neg      = step[ADV_WIDTH];
      s1_in.a_lo     = a_lo;
      s1_in.period   = pop_item.period;
      s1_in.prod     = '0;
      s1_in.span_idx = '0;
      if (pop_item.interp) begin
         s1_in.prod     = PRODUCT_WIDTH'(step_mag) * PRODUCT_WIDTH'(pop_item.offset);
         s1_in.span_idx = SPAN_IDX_WIDTH'(pop_item.lo_idx - 1'b1);
      end
      s1_valid_in = advance ? !q_status.empty : s1_valid_ff;
   end

   // Stage 2: quotient estimate through the span's reciprocal.
   always_comb begin
      recip_product  = RECIP_PROD_WIDTH'(s1_ff.prod)
                       * RECIP_PROD_WIDTH'(SPAN_RECIP[s1_ff.span_idx]);
      s2_in.kind     = s1_ff.kind;
      s2_in.neg      = s1_ff.neg;
      s2_in.prod     = s1_ff.prod;
      s2_in.a_lo     = s1_ff.a_lo;
      s2_in.span_idx = s1_ff.span_idx;
      s2_in.period   = s1_ff.period;
      s2_in.q_est    = recip_product[RECIP_WIDTH +: ADV_WIDTH];
      s2_valid_in    = advance ? s1_valid_ff : s2_valid_ff;
   end

   // Stage 3: the estimate may be one short; the remainder tells.
   always_comb begin
      back_product = PRODUCT_WIDTH'(s2_ff.q_est) * PRODUCT_WIDTH'(SPAN[s2_ff.span_idx]);
      remainder    = s2_ff.prod - back_product;
      s3_in.kind   = s2_ff.kind;
      s3_in.neg    = s2_ff.neg;
      s3_in.a_lo   = s2_ff.a_lo;
      s3_in.period = s2_ff.period;
      s3_in.quot   = (remainder >= PRODUCT_WIDTH'(SPAN[s2_ff.span_idx]))
                     ? s2_ff.q_est + 1'b1 : s2_ff.q_est;
      s3_valid_in  = advance ? s2_valid_ff : s3_valid_ff;
   end

   // Stage 4: final advance, saturating compare and the engine state.
   always_comb begin
      adv_sum     = s3_ff.neg ? {1'b0, s3_ff.a_lo} - {1'b0, s3_ff.quot}
                              : {1'b0, s3_ff.a_lo} + {1'b0, s3_ff.quot};
      adv_new     = adv_sum[ADV_WIDTH-1:0];
      period_ext  = ADV_WIDTH'(s3_ff.period);
      compare_new = (adv_new >= period_ext) ? '0 : period_ext - adv_new;

      rsp_valid_in = advance ? s3_valid_ff : rsp_valid_ff;
      overflow_in  = overflow_ff;
      stop_in      = stop_ff;
      accepted_in  = accepted_ff;
      compare_in   = compare_ff;
      adv_reg_in   = adv_reg_ff;
      rev_in       = rev_ff;
      if (advance && s3_valid_ff) begin
         accepted_in = 1'b0;
         case (s3_ff.kind)
            KIND_OVERFLOW: begin
               overflow_in = 1'b1;
            end
            KIND_PULSE: begin
               accepted_in = 1'b1;
               overflow_in = 1'b0;
               stop_in     = 1'b0;
               rev_in      = rev_ff + 1'b1;
               adv_reg_in  = adv_new;
               compare_in  = compare_new;
            end
            KIND_REJECT: begin
               if (overflow_ff) begin
                  stop_in    = 1'b1;
                  compare_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff       <= ADV_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         stop_ff      <= 1'b0;
         accepted_ff  <= 1'b0;
         compare_ff   <= COMPARE_RESET;
         adv_reg_ff   <= '0;
         rev_ff       <= '0;
      end else begin
         tab_ff       <= tab_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         overflow_ff  <= overflow_in;
         stop_ff      <= stop_in;
         accepted_ff  <= accepted_in;
         compare_ff   <= compare_in;
         adv_reg_ff   <= adv_reg_in;
         rev_ff       <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_spark_compare  = compare_ff;
   assign rsp_advance_ticks  = adv_reg_ff;
   assign rsp_stopped        = stop_ff;
   assign rsp_pulse_accepted = accepted_ff;
   assign rsp_revolutions    = rev_ff;

   // A stopped engine never carries a spark compare.
   a_stop_zero_compare: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> (compare_ff == '0))
      else $error("stop state with nonzero spark compare");

   // An accepted pulse always clears the stop state.
   a_accept_not_stopped: assert property (@(posedge clock) disable iff (reset)
      !(stop_ff && accepted_ff))
      else $error("accepted pulse left the engine stopped");

   // A held result word keeps the engine state frozen.
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable(rev_ff) && $stable(compare_ff) && $stable(stop_ff)))
      else $error("engine state moved while the result was stalled");

   // Each accepted pulse counts exactly one revolution.
   a_rev_count: assert property (@(posedge clock) disable iff (reset)
      (advance && s3_valid_ff && s3_ff.kind == KIND_PULSE) |=>
         (rev_ff == $past(rev_ff) + 1'b1))
      else $error("revolution count did not step on an accepted pulse");

endmodule

`default_nettype wire
